// ===== sv/mbst_pkg.sv =====
// shared types and constants for the max bottleneck spanning tree block
package mbst_pkg;

    // default sizing
    localparam int MBST_MAX_VERTICES = 16;
    localparam int MBST_CAP_BITS     = 16;

    // fixed widths of the word fields
    localparam int OP_BITS         = 2;
    localparam int VERTEX_BITS     = 4;
    localparam int CAPACITY_BITS   = 16;
    localparam int COUNT_BITS      = 5;
    localparam int BOTTLENECK_BITS = 16;

    // command codes
    typedef enum logic [OP_BITS-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_SOLVE = 2'd2
    } mbst_op_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_READ,
        ST_ADD_CHECK,
        ST_ADD_MIRROR,
        ST_PASS,
        ST_DRAIN,
        ST_STEP
    } mbst_state_t;

    // status from the sequencer to the top level
    typedef struct packed {
        logic busy;
        logic done;
        logic no_edge;
    } mbst_status_t;

endpackage

// ===== sv/mbst_ram.sv =====
// generic single write port ram with registered read
module mbst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mbst_ctrl.sv =====
// sequencer for clear, edge load and prim growth over the two rams
module mbst_ctrl
    import mbst_pkg::*;
#(
    parameter int MAX_VERTICES = MBST_MAX_VERTICES,
    parameter int CAP_BITS     = MBST_CAP_BITS,
    localparam int VW          = $clog2(MAX_VERTICES),
    localparam int AW          = 2 * VW
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [OP_BITS-1:0]         op,
    input  logic [VERTEX_BITS-1:0]     vertex_a,
    input  logic [VERTEX_BITS-1:0]     vertex_b,
    input  logic [CAPACITY_BITS-1:0]   capacity,
    input  logic [COUNT_BITS-1:0]      vertex_count,
    output logic                       edge_we,
    output logic [AW-1:0]              edge_waddr,
    output logic [CAP_BITS-1:0]        edge_wdata,
    output logic [AW-1:0]              edge_raddr,
    input  logic [CAP_BITS-1:0]        edge_rdata,
    output logic                       best_we,
    output logic [VW-1:0]              best_waddr,
    output logic [CAP_BITS-1:0]        best_wdata,
    output logic [VW-1:0]              best_raddr,
    input  logic [CAP_BITS-1:0]        best_rdata,
    output mbst_status_t               status,
    output logic [BOTTLENECK_BITS-1:0] bottleneck
);

    localparam int CW = $clog2(MAX_VERTICES + 1);

    mbst_state_t state_reg, state_next;

    logic [AW-1:0]              sweep_reg, sweep_next;
    logic [VW-1:0]              a_reg, a_next;
    logic [VW-1:0]              b_reg, b_next;
    logic [CAP_BITS-1:0]        cap_reg, cap_next;
    logic [CW-1:0]              n_reg, n_next;
    logic [VW-1:0]              pick_reg, pick_next;
    logic [CW-1:0]              j_reg, j_next;
    logic [VW-1:0]              jd_reg, jd_next;
    logic                       dv_reg, dv_next;
    logic                       first_reg, first_next;
    logic [CAP_BITS-1:0]        top_reg, top_next;
    logic [VW-1:0]              top_idx_reg, top_idx_next;
    logic [MAX_VERTICES-1:0]    in_tree_reg, in_tree_next;
    logic [CAP_BITS-1:0]        min_reg, min_next;
    logic                       taken_reg, taken_next;
    logic                       valid_reg, valid_next;
    logic [BOTTLENECK_BITS-1:0] bottleneck_reg, bottleneck_next;
    logic                       no_edge_reg, no_edge_next;

    logic                a_ok;
    logic                b_ok;
    logic [CAP_BITS-1:0] cap_in;
    logic [CW-1:0]       n_in;
    logic [CAP_BITS-1:0] old_link;
    logic [CAP_BITS-1:0] new_link;
    logic                link_up;

    assign a_ok   = int'(vertex_a) < MAX_VERTICES;
    assign b_ok   = int'(vertex_b) < MAX_VERTICES;
    assign cap_in = CAP_BITS'(capacity);
    assign n_in   = (int'(vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                        : CW'(vertex_count);

    // relax one link: the first pass loads row zero over an empty table
    assign old_link = first_reg ? '0 : best_rdata;
    assign link_up  = !in_tree_reg[jd_reg] && (edge_rdata > old_link);
    assign new_link = link_up ? edge_rdata : old_link;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            sweep_reg      <= '0;
            dv_reg         <= 1'b0;
            in_tree_reg    <= '0;
            taken_reg      <= 1'b0;
            valid_reg      <= 1'b0;
            bottleneck_reg <= '0;
            no_edge_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            dv_reg         <= dv_next;
            in_tree_reg    <= in_tree_next;
            taken_reg      <= taken_next;
            valid_reg      <= valid_next;
            bottleneck_reg <= bottleneck_next;
            no_edge_reg    <= no_edge_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        cap_reg     <= cap_next;
        n_reg       <= n_next;
        pick_reg    <= pick_next;
        j_reg       <= j_next;
        jd_reg      <= jd_next;
        first_reg   <= first_next;
        top_reg     <= top_next;
        top_idx_reg <= top_idx_next;
        min_reg     <= min_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sweep_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_ADD:
                        begin
                            if (a_ok && b_ok)
                            begin
                                state_next = ST_ADD_READ;
                            end
                        end
                        OP_SOLVE:
                        begin
                            if (n_in != '0)
                            begin
                                state_next = ST_PASS;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_READ:   state_next = ST_ADD_CHECK;
            ST_ADD_CHECK:  state_next = (cap_reg > edge_rdata) ? ST_ADD_MIRROR : ST_IDLE;
            ST_ADD_MIRROR: state_next = ST_IDLE;
            ST_PASS:
            begin
                if (j_reg + CW'(1) == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_STEP;
            ST_STEP:  state_next = (top_reg == '0) ? ST_IDLE : ST_PASS;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and memory ports
    always_comb
    begin
        sweep_next      = sweep_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        cap_next        = cap_reg;
        n_next          = n_reg;
        pick_next       = pick_reg;
        j_next          = j_reg;
        jd_next         = jd_reg;
        dv_next         = 1'b0;
        first_next      = first_reg;
        top_next        = top_reg;
        top_idx_next    = top_idx_reg;
        in_tree_next    = in_tree_reg;
        min_next        = min_reg;
        taken_next      = taken_reg;
        valid_next      = 1'b0;
        bottleneck_next = bottleneck_reg;
        no_edge_next    = no_edge_reg;

        edge_we    = 1'b0;
        edge_waddr = {a_reg, b_reg};
        edge_wdata = cap_reg;
        edge_raddr = {pick_reg, j_reg[VW-1:0]};
        best_we    = 1'b0;
        best_waddr = jd_reg;
        best_wdata = new_link;
        best_raddr = j_reg[VW-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                edge_we    = 1'b1;
                edge_waddr = sweep_reg;
                edge_wdata = '0;
                sweep_next = sweep_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_CLEAR: sweep_next = '0;
                        OP_ADD:
                        begin
                            a_next   = VW'(vertex_a);
                            b_next   = VW'(vertex_b);
                            cap_next = cap_in;
                        end
                        OP_SOLVE:
                        begin
                            n_next          = n_in;
                            pick_next       = '0;
                            j_next          = '0;
                            first_next      = 1'b1;
                            top_next        = '0;
                            top_idx_next    = '0;
                            in_tree_next    = '0;
                            in_tree_next[0] = 1'b1;
                            taken_next      = 1'b0;
                            min_next        = '1;
                            // nothing to grow from
                            if (n_in == '0)
                            begin
                                valid_next      = 1'b1;
                                bottleneck_next = '0;
                                no_edge_next    = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADD_READ:
            begin
                edge_raddr = {a_reg, b_reg};
            end
            ST_ADD_CHECK:
            begin
                // matrix stays symmetric, one read covers both entries
                if (cap_reg > edge_rdata)
                begin
                    edge_we = 1'b1;
                end
            end
            ST_ADD_MIRROR:
            begin
                edge_we    = 1'b1;
                edge_waddr = {b_reg, a_reg};
            end
            ST_PASS:
            begin
                dv_next = 1'b1;
                jd_next = j_reg[VW-1:0];
                j_next  = j_reg + CW'(1);
            end
            ST_STEP:
            begin
                if (top_reg == '0)
                begin
                    valid_next      = 1'b1;
                    bottleneck_next = taken_reg ? BOTTLENECK_BITS'(min_reg) : '0;
                    no_edge_next    = !taken_reg;
                end
                else
                begin
                    in_tree_next[top_idx_reg] = 1'b1;
                    taken_next                = 1'b1;
                    if (top_reg < min_reg)
                    begin
                        min_next = top_reg;
                    end
                    pick_next    = top_idx_reg;
                    j_next       = '0;
                    first_next   = 1'b0;
                    top_next     = '0;
                    top_idx_next = '0;
                end
            end
            default: ;
        endcase

        // returning read data: write back the relaxed link, track the best
        if (dv_reg)
        begin
            best_we = 1'b1;
            if (!in_tree_reg[jd_reg] && (new_link > top_reg))
            begin
                top_next     = new_link;
                top_idx_next = jd_reg;
            end
        end
    end

    assign status.busy    = (state_reg != ST_IDLE);
    assign status.done    = valid_reg;
    assign status.no_edge = no_edge_reg;
    assign bottleneck     = bottleneck_reg;

endmodule

// ===== sv/max_bottleneck_spanning_tree_top.sv =====
// top level of the max bottleneck spanning tree block
//
// A command word is taken when start is high and busy is low. Clear zeroes the
// whole capacity matrix with a sweep of one ram word per cycle; the same sweep
// runs right after reset, and busy stays high until it ends. An add steps
// through accept, read, compare and write, and mirror write; it stops after the
// compare when the new capacity is not larger than the stored one so nothing is
// written, and ends at the accept when an endpoint is out of range. A solve runs
// dense prim growth: each tree step is one pass over the n vertices in use,
// reading one capacity word and one link word per cycle, as each memory has a
// single ram read port; a solve with no vertices answers straight from idle.
// Only a solve yields a result word:
// done is high for exactly one cycle with bottleneck and no_edge, and there is
// no way to hold it, so the receiver must take it in that cycle.
module max_bottleneck_spanning_tree_top
    import mbst_pkg::*;
#(
    parameter int MAX_VERTICES = MBST_MAX_VERTICES,
    parameter int CAP_BITS     = MBST_CAP_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OP_BITS-1:0]         op,
    input  logic [VERTEX_BITS-1:0]     vertex_a,
    input  logic [VERTEX_BITS-1:0]     vertex_b,
    input  logic [CAPACITY_BITS-1:0]   capacity,
    input  logic [COUNT_BITS-1:0]      vertex_count,
    output logic                       done,
    output logic [BOTTLENECK_BITS-1:0] bottleneck,
    output logic                       no_edge
);

    // index widths: matrix address is {row, column}
    localparam int VW         = $clog2(MAX_VERTICES);
    localparam int AW         = 2 * VW;
    localparam int EDGE_DEPTH = 1 << AW;
    localparam int BEST_DEPTH = 1 << VW;

    logic                edge_we;
    logic [AW-1:0]       edge_waddr;
    logic [CAP_BITS-1:0] edge_wdata;
    logic [AW-1:0]       edge_raddr;
    logic [CAP_BITS-1:0] edge_rdata;
    logic                best_we;
    logic [VW-1:0]       best_waddr;
    logic [CAP_BITS-1:0] best_wdata;
    logic [VW-1:0]       best_raddr;
    logic [CAP_BITS-1:0] best_rdata;
    mbst_status_t        status;

    // sequencer: command decode, rmw of matrix words, prim passes
    mbst_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .CAP_BITS     (CAP_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (op),
        .vertex_a     (vertex_a),
        .vertex_b     (vertex_b),
        .capacity     (capacity),
        .vertex_count (vertex_count),
        .edge_we      (edge_we),
        .edge_waddr   (edge_waddr),
        .edge_wdata   (edge_wdata),
        .edge_raddr   (edge_raddr),
        .edge_rdata   (edge_rdata),
        .best_we      (best_we),
        .best_waddr   (best_waddr),
        .best_wdata   (best_wdata),
        .best_raddr   (best_raddr),
        .best_rdata   (best_rdata),
        .status       (status),
        .bottleneck   (bottleneck)
    );

    // capacity matrix, kept symmetric by the add sequence
    mbst_ram #(
        .WIDTH (CAP_BITS),
        .DEPTH (EDGE_DEPTH)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    // best link into the tree for each vertex in use, rewritten on each pass
    mbst_ram #(
        .WIDTH (CAP_BITS),
        .DEPTH (BEST_DEPTH)
    ) u_best_ram (
        .clk   (clk),
        .we    (best_we),
        .waddr (best_waddr),
        .wdata (best_wdata),
        .raddr (best_raddr),
        .rdata (best_rdata)
    );

    assign busy    = status.busy;
    assign done    = status.done;
    assign no_edge = status.no_edge;

endmodule

// ===== sv/mbst_checker.sv =====
// port level checks for the max bottleneck spanning tree block, with bind
module mbst_checker
    import mbst_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [OP_BITS-1:0]         op,
    input logic [VERTEX_BITS-1:0]     vertex_a,
    input logic [VERTEX_BITS-1:0]     vertex_b,
    input logic [CAPACITY_BITS-1:0]   capacity,
    input logic [COUNT_BITS-1:0]      vertex_count,
    input logic                       done,
    input logic [BOTTLENECK_BITS-1:0] bottleneck,
    input logic                       no_edge
);

    // a result word lasts one cycle only; a solve taken in that cycle may
    // answer at once when it has no vertices
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !(start && !busy && (op == OP_SOLVE))) |=> !done)
        else $error("done held longer than one cycle");

    // an empty tree reports a zero bottleneck
    a_no_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && no_edge) |-> (bottleneck == '0))
        else $error("no_edge result with nonzero bottleneck");

    // the result comes out as the block goes back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    // a clear always starts a sweep
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_CLEAR)) |=> busy)
        else $error("clear command did not start the sweep");

    // an add command never produces a result
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_ADD)) |=> !done)
        else $error("result word after an add command");

endmodule

bind max_bottleneck_spanning_tree_top mbst_checker u_mbst_checker (.*);
